>>> design/stip_pkg.sv
// shared types and constants for the string to integer parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package stip_pkg;

  localparam int CH_WIDTH    = 8;
  localparam int BASE_WIDTH  = 6;
  localparam int OUT_WIDTH   = 64;
  localparam int INDEX_WIDTH = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;

  // one classified character as it travels from front to back
  typedef struct packed {
    logic                  first;
    logic [BASE_WIDTH-1:0] base;
    logic                  alnum;
    logic [BASE_WIDTH-1:0] dval;
    logic                  space;
    logic                  minus;
    logic                  plus;
    logic                  zero;
    logic                  xchar;
  } stip_item_t;

endpackage

>>> design/stip_front.sv
// input stage: registers each character item and classifies it
// depends on stip_pkg
`timescale 1ns / 1ps

module stip_front
  import stip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CH_WIDTH-1:0]   ch,
  input  logic                  first,
  input  logic [BASE_WIDTH-1:0] base,
  output logic                  push_valid,
  input  logic                  push_ready,
  output stip_item_t            push_item
);

  localparam logic [CH_WIDTH-1:0] C_TAB   = 8'h09;
  localparam logic [CH_WIDTH-1:0] C_CR    = 8'h0D;
  localparam logic [CH_WIDTH-1:0] C_SPACE = 8'h20;
  localparam logic [CH_WIDTH-1:0] C_PLUS  = 8'h2B;
  localparam logic [CH_WIDTH-1:0] C_MINUS = 8'h2D;
  localparam logic [CH_WIDTH-1:0] C_ZERO  = 8'h30;
  localparam logic [CH_WIDTH-1:0] C_NINE  = 8'h39;
  localparam logic [CH_WIDTH-1:0] C_UA    = 8'h41;
  localparam logic [CH_WIDTH-1:0] C_UX    = 8'h58;
  localparam logic [CH_WIDTH-1:0] C_UZ    = 8'h5A;
  localparam logic [CH_WIDTH-1:0] C_LA    = 8'h61;
  localparam logic [CH_WIDTH-1:0] C_LX    = 8'h78;
  localparam logic [CH_WIDTH-1:0] C_LZ    = 8'h7A;
  localparam logic [CH_WIDTH-1:0] TEN     = 8'd10;

  logic       vld;
  stip_item_t item;
  stip_item_t item_next;

  assign in_ready   = !vld || push_ready;
  assign push_valid = vld;
  assign push_item  = item;

  always_comb begin
    item_next       = '0;
    item_next.first = first;
    item_next.base  = base;
    // tab, lf, vt, ff, cr are one contiguous run
    item_next.space = (ch == C_SPACE) || (ch >= C_TAB && ch <= C_CR);
    item_next.minus = (ch == C_MINUS);
    item_next.plus  = (ch == C_PLUS);
    item_next.zero  = (ch == C_ZERO);
    item_next.xchar = (ch == C_LX) || (ch == C_UX);
    if (ch >= C_ZERO && ch <= C_NINE) begin
      item_next.alnum = 1'b1;
      item_next.dval  = BASE_WIDTH'(ch - C_ZERO);
    end else if (ch >= C_LA && ch <= C_LZ) begin
      item_next.alnum = 1'b1;
      item_next.dval  = BASE_WIDTH'(ch - C_LA + TEN);
    end else if (ch >= C_UA && ch <= C_UZ) begin
      item_next.alnum = 1'b1;
      item_next.dval  = BASE_WIDTH'(ch - C_UA + TEN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

>>> design/stip_queue.sv
// short register queue between the classifier and the conversion engine
// depends on stip_pkg
`timescale 1ns / 1ps

module stip_queue
  import stip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  stip_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output stip_item_t pop_item
);

  localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_WIDTH-1:0] FULL = CNT_WIDTH'(QUEUE_DEPTH);

  stip_item_t           slots [QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0] wr_ptr;
  logic [PTR_WIDTH-1:0] rd_ptr;
  logic [CNT_WIDTH-1:0] count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("queue count beyond depth");
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");
  a_pop_hold: assert property (@(posedge clk) disable iff (rst)
    pop_valid && !pop_ready |=> pop_valid)
    else $error("queue output dropped while stalled");
`endif

endmodule

>>> design/stip_back.sv
// conversion engine: sign, prefix and base handling, accumulate, result register
// depends on stip_pkg
`timescale 1ns / 1ps

module stip_back
  import stip_pkg::*;
#(
  parameter int VALUE_WIDTH    = 64,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  stip_item_t                    item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_WIDTH-1:0]   value,
  output logic [INDEX_WIDTH-1:0]        end_index,
  output logic                          overflowed,
  output logic                          any_digits
);

  localparam int MUL_WIDTH  = VALUE_WIDTH + BASE_WIDTH;
  localparam int PROD_WIDTH = MUL_WIDTH + 1;
  localparam logic [VALUE_WIDTH-1:0] TOP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_DONE, PH_SPACE, PH_LEAD, PH_ZERO, PH_PREFIX, PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {ST_NONE, ST_SOME, ST_OVER} status_t;

  phase_t                    phase, phase_next;
  status_t                   status, status_next;
  logic                      negative, negative_next;
  logic [VALUE_WIDTH-1:0]    accumulator, accumulator_next;
  logic [BASE_WIDTH-1:0]     active_base, active_base_next;
  logic [POSITION_WIDTH-1:0] position, position_next;
  logic                      pop;
  logic                      emit;
  logic [VALUE_WIDTH-1:0]    magnitude;

  assign item_ready = !out_valid || out_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    logic                  lead;
    logic                  dig;
    logic [MUL_WIDTH-1:0]  mul;
    logic [PROD_WIDTH-1:0] prod;
    logic [PROD_WIDTH-1:0] limit;
    phase_next       = phase;
    status_next      = status;
    negative_next    = negative;
    accumulator_next = accumulator;
    active_base_next = active_base;
    position_next    = position;
    emit             = 1'b0;
    lead             = 1'b0;
    dig              = 1'b0;
    mul              = '0;
    prod             = '0;
    limit            = '0;
    if (pop) begin
      if (item.first) begin
        phase_next       = PH_SPACE;
        status_next      = ST_NONE;
        negative_next    = 1'b0;
        accumulator_next = '0;
        active_base_next = item.base;
        position_next    = '0;
      end else if (phase != PH_DONE && position != '1) begin
        position_next = position + 1'b1;
      end
      // items while done fall into the done arm and change nothing
      unique case (phase_next)
        PH_DONE: ;
        PH_SPACE: begin
          if (item.space) begin
          end else if (item.minus) begin
            negative_next = 1'b1;
            phase_next    = PH_LEAD;
          end else if (item.plus) begin
            phase_next = PH_LEAD;
          end else begin
            lead = 1'b1;
          end
        end
        PH_LEAD: lead = 1'b1;
        PH_ZERO: begin
          if (item.xchar) begin
            active_base_next = BASE_HEX;
            phase_next       = PH_PREFIX;
          end else begin
            if (active_base_next == BASE_AUTO) begin
              active_base_next = BASE_OCT;
            end
            status_next = ST_SOME;
            phase_next  = PH_DIGITS;
            dig         = 1'b1;
          end
        end
        PH_PREFIX: begin
          phase_next = PH_DIGITS;
          dig        = 1'b1;
        end
        PH_DIGITS: dig = 1'b1;
        default: phase_next = PH_DONE;
      endcase
      if (lead) begin
        if ((active_base_next == BASE_AUTO || active_base_next == BASE_HEX) && item.zero) begin
          phase_next = PH_ZERO;
        end else begin
          if (active_base_next == BASE_AUTO) begin
            active_base_next = BASE_DEC;
          end
          phase_next = PH_DIGITS;
          dig        = 1'b1;
        end
      end
      if (dig) begin
        if (!item.alnum || item.dval >= active_base_next) begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end else begin
          // acc * base + d beyond the limit is the same test as the cutoff compare
          mul   = accumulator_next * active_base_next;
          prod  = PROD_WIDTH'(mul) + PROD_WIDTH'(item.dval);
          limit = PROD_WIDTH'(TOP) - PROD_WIDTH'(!negative_next);
          if (status_next == ST_OVER || prod > limit) begin
            status_next = ST_OVER;
          end else begin
            status_next      = ST_SOME;
            accumulator_next = prod[VALUE_WIDTH-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    if (status_next == ST_OVER) begin
      magnitude = negative_next ? TOP : TOP - 1'b1;
    end else begin
      magnitude = negative_next ? -accumulator_next : accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DONE;
      status      <= ST_NONE;
      negative    <= 1'b0;
      accumulator <= '0;
      active_base <= BASE_DEC;
      position    <= '0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      status      <= status_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
      active_base <= active_base_next;
      position    <= position_next;
      if (emit) begin
        out_valid  <= 1'b1;
        value      <= OUT_WIDTH'(signed'(magnitude));
        end_index  <= (status_next != ST_NONE) ? INDEX_WIDTH'(position_next) : '0;
        overflowed <= (status_next == ST_OVER);
        any_digits <= (status_next != ST_NONE);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_over_has_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflowed |-> any_digits)
    else $error("overflow reported without digits");
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_digits |-> value == '0 && end_index == '0)
    else $error("result without digits is not zero");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("pending result changed while stalled");
`endif

endmodule

>>> design/string_to_integer_parser_unit.sv
// String to integer parser, strtol style, one character per item.
// Input channel: in_valid/in_ready with ch, first and base. An item with
// first set opens a new conversion with the given base (0 auto-detects)
// and drops any conversion still open. Whitespace, one sign and a 0x/0X
// prefix (in base 0 or 16) are taken before the digits; the first non-digit
// closes the conversion and gives one result. Items after that are dropped
// until the next first item.
// Output channel: out_valid/out_ready with value, end_index, overflowed and
// any_digits; a result stays until taken.
// Throughput: one item per cycle unless a pending result is stalled; the
// engine does one multiply-accumulate of the accumulator by the base per cycle.
// Path: the closing item passes the input register, then a queue entry,
// then the result register, which raises out_valid.
// Reset: synchronous; the block is idle, waiting for a first item.
// When the receiver stalls the engine holds once a result is pending, the
// queue fills and then in_ready falls.
// depends on stip_pkg, stip_front, stip_queue, stip_back
`timescale 1ns / 1ps

module string_to_integer_parser_unit
  import stip_pkg::*;
#(
  parameter int VALUE_WIDTH    = 64,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CH_WIDTH-1:0]         ch,
  input  logic                        first,
  input  logic [BASE_WIDTH-1:0]       base,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] value,
  output logic [INDEX_WIDTH-1:0]      end_index,
  output logic                        overflowed,
  output logic                        any_digits
);

  logic       push_valid;
  logic       push_ready;
  stip_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  stip_item_t pop_item;

  stip_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .first      (first),
    .base       (base),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  stip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  stip_back #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .end_index  (end_index),
    .overflowed (overflowed),
    .any_digits (any_digits)
  );

endmodule
